### src/vcfd_pkg.sv
// ----------------------------------------------------------------------------
// vcfd_pkg - shared definitions for the frame deframer
// Header layout offsets, status codes, result word type and magic table.
// ----------------------------------------------------------------------------
package vcfd_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 5;    // header offsets 0..23
   localparam int LEN_W  = 32;

   localparam int HDR_LEN  = 24;
   localparam int TAIL_LEN = 8;

   localparam logic [POS_W-1:0] TYPE_POS = POS_W'(4);
   localparam logic [POS_W-1:0] LEN_POS0 = POS_W'(12);
   localparam logic [POS_W-1:0] LEN_POS1 = POS_W'(13);
   localparam logic [POS_W-1:0] LEN_POS2 = POS_W'(14);
   localparam logic [POS_W-1:0] LEN_POS3 = POS_W'(15);
   localparam logic [POS_W-1:0] EXT_POS  = POS_W'(22);
   localparam logic [POS_W-1:0] SUM_POS  = POS_W'(23);
   localparam logic [POS_W-1:0] MAGIC_LEN = POS_W'(4);

   localparam logic [BYTE_W-1:0] KEY_RESET = 8'hFD;

   localparam logic [1:0] ST_PAYLOAD   = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_BAD_SUM   = 2'd2;
   localparam logic [1:0] ST_BAD_LEN   = 2'd3;

   typedef struct packed {
      logic [1:0]        status;
      logic              last_in_frame;
      logic              key_frame;
      logic [BYTE_W-1:0] payload_byte;
   } res_type;

   function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         2'd0:    val = 8'h44;
         2'd1:    val = 8'h48;
         2'd2:    val = 8'h41;
         2'd3:    val = 8'h56;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### src/vcfd_parser.sv
// ----------------------------------------------------------------------------
// vcfd_parser - frame header parser and body sequencer
// Walks header, extension, payload and tail; one byte per accepted word.
// ----------------------------------------------------------------------------
module vcfd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_fire,
   input  logic [vcfd_pkg::BYTE_W-1:0] in_byte,
   input  logic [vcfd_pkg::BYTE_W-1:0] key_code,
   output logic                        res_valid,
   output vcfd_pkg::res_type           res
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_EXT    = 3'd1;
   localparam logic [2:0] PH_PAY    = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_HALT   = 3'd4;

   localparam int LW = vcfd_pkg::LEN_W;

   logic [2:0]                   phase_ff, phase_in;
   logic [vcfd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [vcfd_pkg::BYTE_W-1:0]  sum_ff, sum_in;
   logic [LW-1:0]                len_ff, len_in;
   logic [vcfd_pkg::BYTE_W-1:0]  ext_ff, ext_in;
   logic                         key_ff, key_in;
   logic [LW-1:0]                cnt_ff, cnt_in;
   logic [LW-1:0]                paym1_ff, paym1_in;
   logic                         paynz_ff, paynz_in;

   logic [LW:0] need_len;
   logic [LW:0] short_diff;
   logic [LW:0] paym1_diff;
   logic        len_short;
   logic        pay_nz;
   logic        cnt_zero;

   // length check and payload count, both from the complete header fields
   always_comb begin
      need_len   = (LW+1)'(vcfd_pkg::HDR_LEN + vcfd_pkg::TAIL_LEN) + (LW+1)'(ext_ff);
      short_diff = {1'b0, len_ff} - need_len;
      paym1_diff = {1'b0, len_ff} - (need_len + (LW+1)'(1));
      len_short  = short_diff[LW];
      pay_nz     = ~paym1_diff[LW];
   end

   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      ext_in    = ext_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      paym1_in  = paym1_ff;
      paynz_in  = paynz_ff;
      res_valid = 1'b0;
      res       = '0;

      if (in_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               if (pos_ff < vcfd_pkg::MAGIC_LEN &&
                   in_byte != vcfd_pkg::magic_byte(pos_ff[1:0])) begin
                  res_valid  = 1'b1;
                  res.status = vcfd_pkg::ST_BAD_MAGIC;
                  phase_in   = PH_HALT;
               end else if (pos_ff == vcfd_pkg::SUM_POS) begin
                  if (in_byte != sum_ff) begin
                     res_valid  = 1'b1;
                     res.status = vcfd_pkg::ST_BAD_SUM;
                     phase_in   = PH_HALT;
                  end else if (len_short) begin
                     res_valid  = 1'b1;
                     res.status = vcfd_pkg::ST_BAD_LEN;
                     phase_in   = PH_HALT;
                  end else begin
                     paym1_in = paym1_diff[LW-1:0];
                     paynz_in = pay_nz;
                     if (ext_ff != '0) begin
                        phase_in = PH_EXT;
                        cnt_in   = LW'(ext_ff) - LW'(1);
                     end else if (pay_nz) begin
                        phase_in = PH_PAY;
                        cnt_in   = paym1_diff[LW-1:0];
                     end else begin
                        phase_in = PH_TAIL;
                        cnt_in   = LW'(vcfd_pkg::TAIL_LEN - 1);
                     end
                  end
               end else begin
                  sum_in = sum_ff + in_byte;
                  pos_in = pos_ff + vcfd_pkg::POS_W'(1);
                  if (pos_ff == vcfd_pkg::TYPE_POS) begin
                     key_in = (in_byte == key_code);
                  end
                  if (pos_ff == vcfd_pkg::EXT_POS) begin
                     ext_in = in_byte;
                  end
                  // total length, little-endian
                  case (pos_ff)
                     vcfd_pkg::LEN_POS0: len_in = LW'(in_byte);
                     vcfd_pkg::LEN_POS1: len_in[15:8]  = in_byte;
                     vcfd_pkg::LEN_POS2: len_in[23:16] = in_byte;
                     vcfd_pkg::LEN_POS3: len_in[31:24] = in_byte;
                     default: ;
                  endcase
               end
            end
            PH_EXT: begin
               if (cnt_zero) begin
                  if (paynz_ff) begin
                     phase_in = PH_PAY;
                     cnt_in   = paym1_ff;
                  end else begin
                     phase_in = PH_TAIL;
                     cnt_in   = LW'(vcfd_pkg::TAIL_LEN - 1);
                  end
               end else begin
                  cnt_in = cnt_ff - LW'(1);
               end
            end
            PH_PAY: begin
               res_valid         = 1'b1;
               res.payload_byte  = in_byte;
               res.key_frame     = key_ff;
               res.last_in_frame = cnt_zero;
               res.status        = vcfd_pkg::ST_PAYLOAD;
               if (cnt_zero) begin
                  phase_in = PH_TAIL;
                  cnt_in   = LW'(vcfd_pkg::TAIL_LEN - 1);
               end else begin
                  cnt_in = cnt_ff - LW'(1);
               end
            end
            PH_TAIL: begin
               if (cnt_zero) begin
                  phase_in = PH_HEADER;
                  pos_in   = '0;
                  sum_in   = '0;
               end else begin
                  cnt_in = cnt_ff - LW'(1);
               end
            end
            PH_HALT: ;
            default: phase_in = PH_HALT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         sum_ff   <= '0;
         len_ff   <= '0;
         ext_ff   <= '0;
         key_ff   <= 1'b0;
         cnt_ff   <= '0;
         paynz_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         ext_ff   <= ext_in;
         key_ff   <= key_in;
         cnt_ff   <= cnt_in;
         paynz_ff <= paynz_in;
      end
   end

   always_ff @(posedge clock) begin
      paym1_ff <= paym1_in;
   end

endmodule

### src/vcfd_skid.sv
// ----------------------------------------------------------------------------
// vcfd_skid - result register with skid stage
// Holds results for the output channel; input side stalls only when full.
// ----------------------------------------------------------------------------
module vcfd_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vcfd_pkg::res_type in_res,
   output logic              in_ready,
   output logic              out_valid,
   output vcfd_pkg::res_type out_res,
   input  logic              out_ready
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   vcfd_pkg::res_type main_ff, main_in;
   vcfd_pkg::res_type skid_ff, skid_in;
   logic              out_fire;
   logic              push;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;
   assign out_fire  = main_valid_ff & out_ready;
   assign push      = in_valid & in_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### src/video_container_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// video_container_frame_deframer_top - byte stream frame deframer
// Strips 24-byte headers, extensions and 8-byte tails; emits payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the raw stream, one byte per word in req_tdata.
//   rsp_* carries results: payload byte in rsp_tdata, last payload byte of a
//   frame on rsp_tlast, key-frame flag and status in rsp_tuser.
//   csr_wen/csr_wdata set the key-frame type code, compared with the type byte
//   of each header as it arrives; write only while the stream is idle.
// Throughput: one byte per cycle while req_tready is high. Each accepted byte
//   is parsed in the cycle it is taken; its result, if any, is registered in
//   the main or skid entry. Non-payload bytes give a word only on a fault.
// Stalls: a two-entry result register (main plus skid) decouples the sides;
//   req_tready drops only once both entries hold undelivered results.
// Faults: a bad magic, checksum or length gives one word with nonzero status
//   and the parser then swallows all input until reset.
// Reset: synchronous; clears the parser to the start of a header, empties
//   the result register and loads the key code with 0xFD.
// ----------------------------------------------------------------------------
module video_container_frame_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast,   // last_in_frame
   output logic [2:0] rsp_tuser,   // [0] key_frame, [2:1] status
   input  logic       csr_wen,
   input  logic [7:0] csr_wdata    // [7:0] key_frame_type_code
);

   logic [vcfd_pkg::BYTE_W-1:0] key_code_ff;
   logic                        in_fire;
   logic                        res_valid;
   vcfd_pkg::res_type           res;
   vcfd_pkg::res_type           out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_code_ff <= vcfd_pkg::KEY_RESET;
      end else if (csr_wen) begin
         key_code_ff <= csr_wdata;
      end
   end

   assign in_fire = req_tvalid & req_tready;

   vcfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req_tdata),
      .key_code  (key_code_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   vcfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = out_res.payload_byte;
   assign rsp_tlast = out_res.last_in_frame;
   assign rsp_tuser = {out_res.status, out_res.key_frame};

   // skid entry only ever fills behind a held main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("skid entry full while output register empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_error_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] != vcfd_pkg::ST_PAYLOAD) |->
         (!rsp_tlast && !rsp_tuser[0] && rsp_tdata == '0))
      else $error("error word carries payload fields");

endmodule
